### rtl/core/atti_pkg.sv
`default_nettype none

package atti_pkg;

    localparam int LEN_BITS    = 6;
    localparam int OFFSET_BITS = 16;
    localparam int STEP_BITS   = 15;
    localparam int TEMP_BITS   = 16;
    localparam int INDEX_BITS  = 5;
    localparam int VALUE_BITS  = 12;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_TABLE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OFFSET_TEMP  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_TEMP    = 2'd2;

    localparam logic [LEN_BITS-1:0]           RST_TABLE_LENGTH = 6'd25;
    localparam logic signed [OFFSET_BITS-1:0] RST_OFFSET_TEMP  = -16'sd400;
    localparam logic [STEP_BITS-1:0]          RST_STEP_TEMP    = 15'd50;

    localparam logic REQ_WRITE   = 1'b0;
    localparam logic REQ_CONVERT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_TAIL,
        ST_SCAN,
        ST_MUL,
        ST_DIV,
        ST_LMUL,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

### rtl/core/atti_ram.sv
`default_nettype none

module atti_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/atti_div.sv
`default_nettype none

module atti_div #(
    parameter int DEN_BITS = 12
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  start,
    input  wire logic [DEN_BITS+atti_pkg::STEP_BITS-1:0] num,
    input  wire logic [DEN_BITS-1:0]                   den,
    output logic                                       done,
    output logic [atti_pkg::STEP_BITS-1:0]             quot
);

    localparam int QB = atti_pkg::STEP_BITS;
    localparam int CB = $clog2(QB + 1);

    logic [DEN_BITS-1:0] rem_reg, rem_next;
    logic [DEN_BITS-1:0] den_reg, den_next;
    logic [QB-1:0]       quot_reg, quot_next;
    logic [CB-1:0]       cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS:0]   diff;
    logic                fits;

    always_comb begin
        trial = {rem_reg, quot_reg[QB-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = trial >= {1'b0, den_reg};

        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start) begin
            // high part of the numerator is known to lie below the divisor
            rem_next  = num[DEN_BITS+QB-1:QB];
            quot_next = num[QB-1:0];
            den_next  = den;
            cnt_next  = CB'(QB);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
            quot_next = {quot_reg[QB-2:0], fits};
            cnt_next  = cnt_reg - CB'(1);
            busy_next = (cnt_reg != CB'(1));
            done_next = (cnt_reg == CB'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
        cnt_reg  <= cnt_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

### rtl/core/adc_table_temperature_interpolator.sv
// Converts raw ADC readings to temperature through a descending breakpoint table held in a
// single-port-write, registered-read RAM. A write beat (req_type 0) stores one breakpoint;
// slots at or beyond TABLE_DEPTH are dropped. A conversion beat (req_type 1) reads entry 0 and
// the last entry in use to catch the clamped ends, then walks the table one entry per cycle
// from entry 1 until it finds the segment, keeping the running segment temperature in an
// accumulator, and finally divides inside the segment with a bit-serial divider that produces
// one quotient bit per cycle, unless the segment's two breakpoints are equal. A conversion's
// run time is dominated by the table walk through the RAM read port and the divider. Results
// sit in an output register, so further beats are taken while a result waits. Configuration
// (0 table_length, 1 offset_temp, 2 step_temp) is written over the cfg channel; the user must
// write it only while the block is idle, as cfg_ready is held high and the block leaves this
// to the user. table_length is clamped to 2..TABLE_DEPTH.

`default_nettype none

module adc_table_temperature_interpolator #(
    parameter int TABLE_DEPTH = 32,
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_req_type,
    input  wire logic [atti_pkg::INDEX_BITS-1:0]     s_entry_index,
    input  wire logic [atti_pkg::VALUE_BITS-1:0]     s_entry_value,
    input  wire logic [atti_pkg::VALUE_BITS-1:0]     s_adc_sample,

    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [atti_pkg::TEMP_BITS-1:0]    m_temperature,

    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [atti_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [atti_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int SW  = SAMPLE_BITS;
    localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int LW  = $clog2(TABLE_DEPTH + 1);
    localparam int QB  = atti_pkg::STEP_BITS;
    localparam int MW  = (LW > SW) ? LW : SW;
    localparam int PW  = MW + QB;
    localparam int NW  = SW + QB;
    localparam int RW  = LW + QB + 2;
    localparam int TW  = atti_pkg::TEMP_BITS;

    localparam logic signed [RW-1:0] SAT_MAX = RW'(32'sd32767);
    localparam logic signed [RW-1:0] SAT_MIN = RW'(-32'sd32768);

    // configuration
    logic [atti_pkg::LEN_BITS-1:0]           length_reg;
    logic signed [atti_pkg::OFFSET_BITS-1:0] offset_reg;
    logic [QB-1:0]                           step_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg <= atti_pkg::RST_TABLE_LENGTH;
            offset_reg <= atti_pkg::RST_OFFSET_TEMP;
            step_reg   <= atti_pkg::RST_STEP_TEMP;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                atti_pkg::CFG_TABLE_LENGTH: length_reg <= cfg_data[atti_pkg::LEN_BITS-1:0];
                atti_pkg::CFG_OFFSET_TEMP:  offset_reg <= cfg_data[atti_pkg::OFFSET_BITS-1:0];
                atti_pkg::CFG_STEP_TEMP:    step_reg   <= cfg_data[QB-1:0];
                default: ;
            endcase
        end
    end

    // effective table length
    logic [LW-1:0] eff_len;

    always_comb begin
        if (int'(length_reg) < 2) begin
            eff_len = LW'(2);
        end else if (int'(length_reg) > TABLE_DEPTH) begin
            eff_len = LW'(TABLE_DEPTH);
        end else begin
            eff_len = LW'(length_reg);
        end
    end

    // breakpoint memory
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [SW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [SW-1:0] mem_rdata;

    atti_ram #(
        .WIDTH(SW),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    // divider
    logic          div_start;
    logic [NW-1:0] div_num;
    logic [SW-1:0] div_den;
    logic          div_done;
    logic [QB-1:0] div_quot;

    atti_div #(
        .DEN_BITS(SW)
    ) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .done   (div_done),
        .quot   (div_quot)
    );

    // sequencer
    atti_pkg::state_t  state_reg, state_next;
    logic [SW-1:0]     sample_reg, sample_next;
    logic [SW-1:0]     hi_reg, hi_next;
    logic [SW-1:0]     lo_reg, lo_next;
    logic [AW-1:0]     rptr_reg, rptr_next;
    logic signed [RW-1:0] acc_reg, acc_next;
    logic [PW-1:0]     prod_reg, prod_next;
    logic [MW-1:0]     mul_a;
    logic              out_valid_reg, out_valid_next;
    logic signed [TW-1:0] out_data_reg, out_data_next;
    logic signed [RW-1:0] offset_ext;
    logic signed [RW-1:0] step_ext;
    logic signed [TW-1:0] acc_sat;

    assign offset_ext = RW'(offset_reg);
    assign step_ext   = $signed(RW'(step_reg));
    assign div_num    = NW'(prod_reg);
    assign div_den    = hi_reg - lo_reg;
    assign mem_wdata  = SW'(s_entry_value);
    assign mem_waddr  = AW'(s_entry_index);

    always_comb begin
        if (acc_reg > SAT_MAX) begin
            acc_sat = TW'(SAT_MAX);
        end else if (acc_reg < SAT_MIN) begin
            acc_sat = TW'(SAT_MIN);
        end else begin
            acc_sat = TW'(acc_reg);
        end
    end

    always_comb begin
        state_next     = state_reg;
        sample_next    = sample_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        rptr_next      = rptr_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        s_ready        = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        div_start      = 1'b0;
        mul_a          = (state_reg == atti_pkg::ST_TAIL) ? MW'(eff_len) : MW'(hi_reg - sample_reg);

        if (m_valid && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            atti_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_req_type == atti_pkg::REQ_WRITE) begin
                        mem_we = (32'(s_entry_index) < TABLE_DEPTH);
                    end else begin
                        sample_next = SW'(s_adc_sample);
                        mem_re      = 1'b1;
                        mem_raddr   = '0;
                        state_next  = atti_pkg::ST_HEAD;
                    end
                end
            end
            atti_pkg::ST_HEAD: begin
                if (sample_reg >= mem_rdata) begin
                    acc_next   = offset_ext;
                    state_next = atti_pkg::ST_DONE;
                end else begin
                    hi_next    = mem_rdata;
                    mem_re     = 1'b1;
                    mem_raddr  = AW'(eff_len - LW'(1));
                    state_next = atti_pkg::ST_TAIL;
                end
            end
            atti_pkg::ST_TAIL: begin
                if (sample_reg <= mem_rdata) begin
                    prod_next  = PW'(mul_a * step_reg);
                    state_next = atti_pkg::ST_LMUL;
                end else begin
                    acc_next   = offset_ext;
                    rptr_next  = AW'(1);
                    mem_re     = 1'b1;
                    mem_raddr  = AW'(1);
                    state_next = atti_pkg::ST_SCAN;
                end
            end
            atti_pkg::ST_SCAN: begin
                if (mem_rdata <= sample_reg) begin
                    lo_next    = mem_rdata;
                    prod_next  = PW'(mul_a * step_reg);
                    state_next = (mem_rdata == hi_reg) ? atti_pkg::ST_DONE : atti_pkg::ST_MUL;
                end else begin
                    hi_next    = mem_rdata;
                    acc_next   = acc_reg + step_ext;
                    rptr_next  = rptr_reg + AW'(1);
                    mem_re     = 1'b1;
                    mem_raddr  = rptr_reg + AW'(1);
                end
            end
            atti_pkg::ST_MUL: begin
                div_start  = 1'b1;
                state_next = atti_pkg::ST_DIV;
            end
            atti_pkg::ST_DIV: begin
                if (div_done) begin
                    acc_next   = acc_reg + $signed(RW'(div_quot));
                    state_next = atti_pkg::ST_DONE;
                end
            end
            atti_pkg::ST_LMUL: begin
                acc_next   = offset_ext + $signed(RW'(prod_reg));
                state_next = atti_pkg::ST_DONE;
            end
            atti_pkg::ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = acc_sat;
                    state_next     = atti_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = atti_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= atti_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        sample_reg   <= sample_next;
        hi_reg       <= hi_next;
        lo_reg       <= lo_next;
        rptr_reg     <= rptr_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_temperature = out_data_reg;

endmodule

`default_nettype wire
